### design/gfq_pkg.sv
// Shared constants, sine/cosine tables and rounding helpers for the ground footprint block.
`timescale 1ns / 1ps

package gfq_pkg;

	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);

	// Q2.30 value of pi
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	localparam int POS_W = 32;
	localparam int VEL_W = 24;
	localparam int DIM_W = 16;
	localparam int TRIG_W = 16;
	localparam int DIFF_W = DIM_W + 1;
	localparam int TV_W = DIM_W + 1 + VEL_W;
	localparam int PROD_W = TRIG_W + DIFF_W + 1;
	localparam int CORNER_W = 50;
	localparam int FRAC_SHIFT = 14;
	localparam int VEL_SHIFT = 6;

	localparam logic signed [POS_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [POS_W-1:0] SAT_MIN = 32'sh8000_0000;

	typedef logic signed [TRIG_W-1:0] trig_tab_t [SINE_TABLE_ENTRIES];

	// Sine of a first-quadrant angle (0..16384 of a turn), Q1.14
	function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [14:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x = (64'(r) * PI_Q30) >> 15;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		// odd terms of the series, divisors (2n)(2n+1), signs alternating
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum = sum - $signed(term);
		if (sum < 0)
			sum = 64'sd0;
		sum = (sum + 64'sd32768) >>> 16;
		if (sum > 64'sd16384)
			sum = 64'sd16384;
		return TRIG_W'(sum);
	endfunction

	function automatic logic signed [TRIG_W-1:0] bam_sine(input logic [15:0] p);
		logic [14:0] r;
		logic signed [TRIG_W-1:0] v;
		r = {1'b0, p[13:0]};
		if (p[14])
			r = 15'd16384 - r;
		v = quarter_sine(r);
		return p[15] ? -v : v;
	endfunction

	// Cosine entry k is the sine a quarter turn further on
	function automatic trig_tab_t build_table(input logic cosine);
		trig_tab_t tab;
		logic [15:0] p;
		for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
			p = 16'((64'(k) * 64'd65536) / SINE_TABLE_ENTRIES);
			if (cosine)
				p = p + 16'd16384;
			tab[k] = bam_sine(p);
		end
		return tab;
	endfunction

	localparam trig_tab_t SIN_TAB = build_table(1'b0);
	localparam trig_tab_t COS_TAB = build_table(1'b1);

	// Scale 2^-22 to Q23.8: round half up, then clamp to 32 signed bits
	function automatic logic signed [POS_W-1:0] round_sat(input logic signed [CORNER_W-1:0] v);
		logic signed [CORNER_W-1:0] q;
		q = (v + CORNER_W'(8192)) >>> FRAC_SHIFT;
		if (q[CORNER_W-1:POS_W-1] == '0 || q[CORNER_W-1:POS_W-1] == '1)
			return q[POS_W-1:0];
		return q[CORNER_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

endpackage

### design/ground_footprint_quad_core.sv
// Top level: five-stage pipeline computing a vehicle's ground rectangle and ground height.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------------
//  input   | in_valid / in_ready    | pos_x/y/z, vel_x/z, heading, gear_down, dims, time
//  output  | out_valid / out_ready  | valid_res, corner0..3 x/z, ground_y
//
// One beat enters per cycle unless out_ready stalls the pipeline.
// Its depth: decode, table read, multiply, sum and round stages, in that order.
// Each stage stalls only when it is full and the stage after it cannot take its beat,
// so bubbles close up and no beat is lost or repeated.
// arst_n clears the valid bits only; the tables are constant and need no setup.
`timescale 1ns / 1ps

module ground_footprint_quad_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [gfq_pkg::POS_W-1:0]      pos_x,
	input  logic signed [gfq_pkg::POS_W-1:0]      pos_y,
	input  logic signed [gfq_pkg::POS_W-1:0]      pos_z,
	input  logic signed [gfq_pkg::VEL_W-1:0]      vel_x,
	input  logic signed [gfq_pkg::VEL_W-1:0]      vel_z,
	input  logic [15:0]                           heading,
	input  logic                                  gear_down,
	input  logic [gfq_pkg::DIM_W-1:0]             body_length,
	input  logic [gfq_pkg::DIM_W-1:0]             cg_offset,
	input  logic [gfq_pkg::DIM_W-1:0]             half_width,
	input  logic [gfq_pkg::DIM_W-1:0]             ref_height,
	input  logic [gfq_pkg::DIM_W-1:0]             lookahead_time,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  valid_res,
	output logic signed [gfq_pkg::POS_W-1:0]      corner0_x,
	output logic signed [gfq_pkg::POS_W-1:0]      corner0_z,
	output logic signed [gfq_pkg::POS_W-1:0]      corner1_x,
	output logic signed [gfq_pkg::POS_W-1:0]      corner1_z,
	output logic signed [gfq_pkg::POS_W-1:0]      corner2_x,
	output logic signed [gfq_pkg::POS_W-1:0]      corner2_z,
	output logic signed [gfq_pkg::POS_W-1:0]      corner3_x,
	output logic signed [gfq_pkg::POS_W-1:0]      corner3_z,
	output logic signed [gfq_pkg::POS_W-1:0]      ground_y
);

	localparam int POS_W = gfq_pkg::POS_W;
	localparam int DIM_W = gfq_pkg::DIM_W;
	localparam int IDX_W = gfq_pkg::IDX_W;
	localparam int TRIG_W = gfq_pkg::TRIG_W;
	localparam int DIFF_W = gfq_pkg::DIFF_W;
	localparam int TV_W = gfq_pkg::TV_W;
	localparam int PROD_W = gfq_pkg::PROD_W;
	localparam int CW = gfq_pkg::CORNER_W;
	localparam int HP_W = 16 + IDX_W;

	// stage enables
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign en_s5 = !vld_s5 || out_ready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1)
				vld_s1 <= in_valid;
			if (en_s2)
				vld_s2 <= vld_s1;
			if (en_s3)
				vld_s3 <= vld_s2;
			if (en_s4)
				vld_s4 <= vld_s3;
			if (en_s5)
				vld_s5 <= vld_s4;
		end
	end

	// ---------------- stage 1: decode, table index, time x velocity, ground height
	logic [HP_W-1:0]            hdg_prod;
	logic signed [POS_W:0]      gy_full;
	logic signed [POS_W-1:0]    gy_sat;

	logic                       ok_s1, moving_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic signed [POS_W-1:0]    px_s1, pz_s1, gy_s1;
	logic signed [TV_W-1:0]     tvx_s1, tvz_s1;
	logic [DIM_W-1:0]           cg_s1, hw_s1;
	logic signed [DIFF_W-1:0]   d_s1;

	assign hdg_prod = HP_W'(heading) * HP_W'(gfq_pkg::SINE_TABLE_ENTRIES);
	assign gy_full = (POS_W+1)'(pos_y) - $signed({1'b0, 16'(ref_height)});
	assign gy_sat = (gy_full[POS_W] != gy_full[POS_W-1])
		? (gy_full[POS_W] ? gfq_pkg::SAT_MIN : gfq_pkg::SAT_MAX)
		: gy_full[POS_W-1:0];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ok_s1     <= gear_down && (pos_x != '0 || pos_z != '0);
			moving_s1 <= (vel_x != '0) || (vel_z != '0);
			idx_s1    <= hdg_prod[HP_W-1:16];
			px_s1     <= pos_x;
			pz_s1     <= pos_z;
			gy_s1     <= gy_sat;
			tvx_s1    <= $signed({1'b0, lookahead_time}) * vel_x;
			tvz_s1    <= $signed({1'b0, lookahead_time}) * vel_z;
			cg_s1     <= cg_offset;
			hw_s1     <= half_width;
			d_s1      <= $signed({1'b0, body_length}) - $signed({1'b0, cg_offset});
		end
	end

	// ---------------- stage 2: table read, front base point
	logic signed [TRIG_W-1:0]   s_s2, c_s2;
	logic                       ok_s2, moving_s2;
	logic signed [POS_W-1:0]    px_s2, pz_s2, gy_s2;
	logic signed [CW-1:0]       ptx_s2, ptz_s2;
	logic [DIM_W-1:0]           cg_s2, hw_s2;
	logic signed [DIFF_W-1:0]   d_s2;

	gfq_trig_rom u_trig (
		.clk     (clk),
		.en      (en_s2),
		.addr    (idx_s1),
		.sin_val (s_s2),
		.cos_val (c_s2)
	);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ok_s2     <= ok_s1;
			moving_s2 <= moving_s1;
			px_s2     <= px_s1;
			pz_s2     <= pz_s1;
			gy_s2     <= gy_s1;
			cg_s2     <= cg_s1;
			hw_s2     <= hw_s1;
			d_s2      <= d_s1;
			ptx_s2    <= (CW'(px_s1) <<< gfq_pkg::FRAC_SHIFT)
				+ (moving_s1 ? (CW'(tvx_s1) <<< gfq_pkg::VEL_SHIFT) : CW'(0));
			ptz_s2    <= (CW'(pz_s1) <<< gfq_pkg::FRAC_SHIFT)
				+ (moving_s1 ? (CW'(tvz_s1) <<< gfq_pkg::VEL_SHIFT) : CW'(0));
		end
	end

	// ---------------- stage 3: rotate dimensions
	logic [DIM_W:0]             cgm;
	logic                       ok_s3;
	logic signed [POS_W-1:0]    px_s3, pz_s3, gy_s3;
	logic signed [CW-1:0]       ptx_s3, ptz_s3;
	logic signed [PROD_W-1:0]   scg_s3, ccg_s3, sd_s3, cd_s3, shw_s3, chw_s3;

	// double the centre offset while moving
	assign cgm = moving_s2 ? {cg_s2, 1'b0} : {1'b0, cg_s2};

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ok_s3  <= ok_s2;
			px_s3  <= px_s2;
			pz_s3  <= pz_s2;
			gy_s3  <= gy_s2;
			ptx_s3 <= ptx_s2;
			ptz_s3 <= ptz_s2;
			scg_s3 <= s_s2 * $signed({1'b0, cgm});
			ccg_s3 <= c_s2 * $signed({1'b0, cgm});
			sd_s3  <= s_s2 * d_s2;
			cd_s3  <= c_s2 * d_s2;
			shw_s3 <= s_s2 * $signed({1'b0, hw_s2});
			chw_s3 <= c_s2 * $signed({1'b0, hw_s2});
		end
	end

	// ---------------- stage 4: front and rear edge centres
	logic                       ok_s4;
	logic signed [POS_W-1:0]    gy_s4;
	logic signed [CW-1:0]       fx_s4, fz_s4, rx_s4, rz_s4;
	logic signed [PROD_W-1:0]   sx_s4, sz_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			ok_s4 <= ok_s3;
			gy_s4 <= gy_s3;
			fx_s4 <= ptx_s3 + CW'(scg_s3);
			fz_s4 <= ptz_s3 - CW'(ccg_s3);
			rx_s4 <= (CW'(px_s3) <<< gfq_pkg::FRAC_SHIFT) - CW'(sd_s3);
			rz_s4 <= (CW'(pz_s3) <<< gfq_pkg::FRAC_SHIFT) + CW'(cd_s3);
			sx_s4 <= chw_s3;
			sz_s4 <= shw_s3;
		end
	end

	// ---------------- stage 5: corners, round and clamp, zero an invalid sample
	logic                       ok_s5;
	logic signed [POS_W-1:0]    c0x_s5, c0z_s5, c1x_s5, c1z_s5;
	logic signed [POS_W-1:0]    c2x_s5, c2z_s5, c3x_s5, c3z_s5, gy_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			ok_s5 <= ok_s4;
			if (ok_s4) begin
				c0x_s5 <= gfq_pkg::round_sat(fx_s4 - CW'(sx_s4));
				c0z_s5 <= gfq_pkg::round_sat(fz_s4 - CW'(sz_s4));
				c1x_s5 <= gfq_pkg::round_sat(fx_s4 + CW'(sx_s4));
				c1z_s5 <= gfq_pkg::round_sat(fz_s4 + CW'(sz_s4));
				c2x_s5 <= gfq_pkg::round_sat(rx_s4 + CW'(sx_s4));
				c2z_s5 <= gfq_pkg::round_sat(rz_s4 + CW'(sz_s4));
				c3x_s5 <= gfq_pkg::round_sat(rx_s4 - CW'(sx_s4));
				c3z_s5 <= gfq_pkg::round_sat(rz_s4 - CW'(sz_s4));
				gy_s5  <= gy_s4;
			end else begin
				c0x_s5 <= '0;
				c0z_s5 <= '0;
				c1x_s5 <= '0;
				c1z_s5 <= '0;
				c2x_s5 <= '0;
				c2z_s5 <= '0;
				c3x_s5 <= '0;
				c3z_s5 <= '0;
				gy_s5  <= '0;
			end
		end
	end

	assign out_valid = vld_s5;
	assign valid_res = ok_s5;
	assign corner0_x = c0x_s5;
	assign corner0_z = c0z_s5;
	assign corner1_x = c1x_s5;
	assign corner1_z = c1z_s5;
	assign corner2_x = c2x_s5;
	assign corner2_z = c2z_s5;
	assign corner3_x = c3x_s5;
	assign corner3_z = c3z_s5;
	assign ground_y  = gy_s5;

	// ---------------- checks
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> corner0_x == '0 && corner1_z == '0
			&& corner2_x == '0 && corner3_z == '0 && ground_y == '0)
		else $error("invalid sample left a nonzero field");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s5 |-> in_ready)
		else $error("input stalled with an empty output stage");

	a_stage1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !en_s2 |=> vld_s1 && $stable(idx_s1) && $stable(px_s1))
		else $error("stalled first stage changed");

	a_ok_pos: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && ok_s1 |-> px_s1 != '0 || pz_s1 != '0)
		else $error("valid flag set for a zero position");

endmodule

### design/gfq_trig_rom.sv
// Sine and cosine lookup with registered read data.
`timescale 1ns / 1ps

module gfq_trig_rom (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic [gfq_pkg::IDX_W-1:0]               addr,
	output logic signed [gfq_pkg::TRIG_W-1:0]       sin_val,
	output logic signed [gfq_pkg::TRIG_W-1:0]       cos_val
);

	localparam gfq_pkg::trig_tab_t SIN_ROM = gfq_pkg::SIN_TAB;
	localparam gfq_pkg::trig_tab_t COS_ROM = gfq_pkg::COS_TAB;

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= SIN_ROM[addr];
			cos_val <= COS_ROM[addr];
		end
	end

endmodule
